### hw/rtl/sat_pkg.sv
// shared types and constants of the sorted alarm table
// alarm key layout, operation codes and stream payload layouts; no dependencies
package sat_pkg;

   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int COUNT_W = 6;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_CLEAR   = 2'd1,
      OP_NEXT    = 2'd2,
      OP_PRESENT = 2'd3
   } op_type;

   // hour in the top bits so that a plain compare gives time order
   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
   } key_type;

   typedef struct packed {
      logic [5:0]        pad;
      logic [SEC_W-1:0]  now_second;
      logic [MIN_W-1:0]  now_minute;
      logic [HOUR_W-1:0] now_hour;
      logic [SEC_W-1:0]  alarm_second;
      logic [MIN_W-1:0]  alarm_minute;
      logic [HOUR_W-1:0] alarm_hour;
   } req_data_type;

   typedef struct packed {
      logic [4:0]         pad;
      logic [COUNT_W-1:0] entry_count;
      logic               arm_new_alarm;
      logic [SEC_W-1:0]   next_second;
      logic [MIN_W-1:0]   next_minute;
      logic [HOUR_W-1:0]  next_hour;
      logic               next_valid;
      logic               table_full;
      logic               found;
   } rsp_data_type;

   typedef struct packed {
      logic clear;
      logic data_valid;
      logic data_first;
   } scan_ctrl_type;

   typedef struct packed {
      logic    found;
      logic    later_seen;
      key_type next_key;
      key_type first_key;
   } scan_stat_type;

endpackage

### hw/rtl/sorted_alarm_table.sv
// sorted alarm table: an operation scans the n stored entries, one memory read a cycle;
// an add of a key not yet stored, with room left, then shifts the entries at and above
// its position p up by one (no shift when p equals n), writes the key at p, and the
// response is posted from the reply state
// one operation at a time; the next request is taken while a response waits
// reset clears the entry count and control state; entry memory is not cleared
module sorted_alarm_table
   import sat_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // alarm_hour, alarm_minute, alarm_second, now_hour, now_minute, now_second
   input  logic [39:0] req_tdata,
   // operation
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // found, table_full, next_valid, next_hour, next_minute, next_second,
   // arm_new_alarm, entry_count
   output logic [31:0] rsp_tdata
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_SHIFT = 5'b00100,
      ST_PLACE = 5'b01000,
      ST_REPLY = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   op_type           op_ff;
   key_type          key_ff, now_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rd_first_ff, rd_first_in;
   logic             issue_ff, issue_in;
   logic [AW-1:0]    wr_addr_ff, wr_addr_in;
   logic             full_ff, full_in;
   logic             insert_ff, insert_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_data_type     rsp_data_ff, rsp_data_in;

   logic             mem_re, mem_we;
   logic [AW-1:0]    mem_raddr, mem_waddr;
   key_type          mem_rdata, mem_wdata;
   scan_ctrl_type    scan_ctrl;
   scan_stat_type    scan_stat;
   logic [CNT_W-1:0] scan_lt;

   req_data_type     req_data;
   key_type          next_key;
   logic             next_valid;

   assign req_data = req_data_type'(req_tdata);

   sat_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata)
   );

   sat_scan #(
      .CNT_W (CNT_W)
   ) u_scan (
      .clock    (clock),
      .ctrl     (scan_ctrl),
      .entry    (mem_rdata),
      .key      (key_ff),
      .now      (now_ff),
      .stat     (scan_stat),
      .lt_count (scan_lt)
   );

   // next alarm of the table as it stands after the operation
   always_comb begin
      next_valid = (count_ff != '0);
      if (insert_ff) begin
         if (scan_stat.later_seen) begin
            next_key = ((key_ff > now_ff) && (key_ff < scan_stat.next_key)) ?
                       key_ff : scan_stat.next_key;
         end else if (key_ff > now_ff) begin
            next_key = key_ff;
         end else begin
            next_key = (scan_lt == '0) ? key_ff : scan_stat.first_key;
         end
      end else begin
         next_key = scan_stat.later_seen ? scan_stat.next_key : scan_stat.first_key;
      end
      if (!next_valid) begin
         next_key = '0;
      end
   end

   always_comb begin
      rsp_data_in               = '0;
      rsp_data_in.found         = scan_stat.found &&
                                  ((op_ff == OP_ADD) || (op_ff == OP_PRESENT));
      rsp_data_in.table_full    = full_ff;
      rsp_data_in.next_valid    = next_valid;
      rsp_data_in.next_hour     = next_key.hour;
      rsp_data_in.next_minute   = next_key.minute;
      rsp_data_in.next_second   = next_key.second;
      rsp_data_in.arm_new_alarm = insert_ff && (next_key == key_ff);
      rsp_data_in.entry_count   = COUNT_W'(count_ff);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = rd_pend_ff;
      rd_first_in  = rd_first_ff;
      issue_in     = issue_ff;
      wr_addr_in   = wr_addr_ff;
      full_in      = full_ff;
      insert_in    = insert_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_re       = 1'b0;
      mem_raddr    = rd_idx_ff[AW-1:0];
      mem_we       = 1'b0;
      mem_waddr    = wr_addr_ff;
      mem_wdata    = mem_rdata;
      scan_ctrl    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rd_idx_in       = '0;
               rd_pend_in      = 1'b0;
               full_in         = 1'b0;
               insert_in       = 1'b0;
               scan_ctrl.clear = 1'b1;
               state_in        = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_ctrl.data_valid = rd_pend_ff;
            scan_ctrl.data_first = rd_first_ff;
            if (rd_idx_ff < count_ff) begin
               mem_re      = 1'b1;
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
               rd_pend_in  = 1'b1;
               rd_first_in = (rd_idx_ff == '0);
            end else begin
               rd_pend_in = 1'b0;
               if (!rd_pend_ff) begin
                  priority if ((op_ff == OP_ADD) && !scan_stat.found &&
                               (count_ff < CNT_W'(TABLE_DEPTH))) begin
                     insert_in = 1'b1;
                     rd_idx_in = count_ff - CNT_W'(1);
                     issue_in  = 1'b1;
                     state_in  = (count_ff == scan_lt) ? ST_PLACE : ST_SHIFT;
                  end else if ((op_ff == OP_ADD) && !scan_stat.found) begin
                     full_in  = 1'b1;
                     state_in = ST_REPLY;
                  end else if (op_ff == OP_CLEAR) begin
                     count_in = '0;
                     state_in = ST_REPLY;
                  end else begin
                     state_in = ST_REPLY;
                  end
               end
            end
         end
         ST_SHIFT: begin
            mem_we = rd_pend_ff;
            if (issue_ff) begin
               mem_re     = 1'b1;
               rd_pend_in = 1'b1;
               wr_addr_in = AW'(rd_idx_ff + CNT_W'(1));
               if (rd_idx_ff == scan_lt) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff - CNT_W'(1);
               end
            end else begin
               rd_pend_in = 1'b0;
               if (!rd_pend_ff) begin
                  state_in = ST_PLACE;
               end
            end
         end
         ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = scan_lt[AW-1:0];
            mem_wdata = key_ff;
            count_in  = count_ff + CNT_W'(1);
            state_in  = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         issue_ff     <= 1'b0;
         full_ff      <= 1'b0;
         insert_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         issue_ff     <= issue_in;
         full_ff      <= full_in;
         insert_ff    <= insert_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      rd_first_ff <= rd_first_in;
      wr_addr_ff  <= wr_addr_in;
      if (req_tvalid && req_tready) begin
         op_ff  <= op_type'(req_tuser);
         key_ff <= {req_data.alarm_hour, req_data.alarm_minute, req_data.alarm_second};
         now_ff <= {req_data.now_hour, req_data.now_minute, req_data.now_second};
      end
      if ((state_ff == ST_REPLY) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !mem_we)
      else $error("memory write during scan");

   a_shift_above_pos: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SHIFT) && rd_pend_ff) |-> (CNT_W'(wr_addr_ff) > scan_lt))
      else $error("shift writes at or below insert position");

endmodule

### hw/rtl/sat_ram.sv
// alarm entry storage: one write port, one registered read port
// depends on sat_pkg for the entry type
module sat_ram
   import sat_pkg::*;
#(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output key_type           rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  key_type           wr_data
);

   key_type mem [DEPTH];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sat_scan.sv
// scan accumulator: folds the entries read in order into match, position
// and next-alarm results; depends on sat_pkg
module sat_scan
   import sat_pkg::*;
#(
   parameter int CNT_W = 6
) (
   input  logic             clock,
   input  scan_ctrl_type    ctrl,
   input  key_type          entry,
   input  key_type          key,
   input  key_type          now,
   output scan_stat_type    stat,
   output logic [CNT_W-1:0] lt_count
);

   scan_stat_type    stat_ff, stat_in;
   logic [CNT_W-1:0] lt_ff, lt_in;

   always_comb begin
      stat_in = stat_ff;
      lt_in   = lt_ff;
      if (ctrl.clear) begin
         stat_in.found      = 1'b0;
         stat_in.later_seen = 1'b0;
         lt_in              = '0;
      end else if (ctrl.data_valid) begin
         if (entry == key) begin
            stat_in.found = 1'b1;
         end
         if (entry < key) begin
            lt_in = lt_ff + CNT_W'(1);
         end
         if (!stat_ff.later_seen && (entry > now)) begin
            stat_in.later_seen = 1'b1;
            stat_in.next_key   = entry;
         end
         if (ctrl.data_first) begin
            stat_in.first_key = entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
      lt_ff   <= lt_in;
   end

   assign stat     = stat_ff;
   assign lt_count = lt_ff;

endmodule
